// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hbc_pkg.sv =====
// shared types, constants and codes of the histogram bin counter
// no dependencies
package hbc_pkg;

   localparam int SampleWidth    = 16;
   localparam int CountWidth     = 32;
   localparam int BinsWidth      = 9;
   localparam int IndexWidth     = 8;
   localparam int DefaultMaxBins = 256;

   // divider geometry: quotient is always below the bin count
   localparam int QuotWidth = BinsWidth;
   localparam int DiffWidth = SampleWidth + 1;
   localparam int ProdWidth = DiffWidth + QuotWidth;

   localparam int CmdWidth = 2;
   localparam logic [CmdWidth-1:0] CmdAdd       = 2'd0;
   localparam logic [CmdWidth-1:0] CmdRead      = 2'd1;
   localparam logic [CmdWidth-1:0] CmdReadClear = 2'd2;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam logic [CsrIndexWidth-1:0] CsrLowLimit  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrHighLimit = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrBinsInUse = 2'd2;

   localparam logic [SampleWidth-1:0] LowLimitReset  = 16'sd0;
   localparam logic [SampleWidth-1:0] HighLimitReset = 16'sd32767;
   localparam logic [BinsWidth-1:0]   BinsInUseReset = 9'd256;

   typedef struct packed {
      logic [CmdWidth-1:0]           command;
      logic signed [SampleWidth-1:0] sample;
      logic [IndexWidth-1:0]         read_bin;
   } req_type;

   typedef struct packed {
      logic [IndexWidth-1:0] bin_index;
      logic                  counted;
      logic [CountWidth-1:0] count_value;
   } rsp_type;

endpackage

// ===== rtl/core/histogram_bin_counter.sv =====
// Histogram of signed samples over equal-width bins between low_limit and high_limit.
//
// req channel: one transaction per command. Add places the sample in bin
// floor((sample - low) * bins / (high - low)) and bumps that bin's count,
// saturating; samples below low, at or above high, or with an empty range or zero
// bins in use are not counted and return all zeros. Read returns a bin's count, read-and-clear
// also zeroes it. Command 3 returns all zeros.
// rsp channel: exactly one transaction per req transaction, in order.
// csr channel: always ready; index 0 low_limit, 1 high_limit, 2 bins_in_use.
// Write it only while no command is in flight.
// Throughput: one command at a time. A counted add passes prep, multiply, the
// nine-step restoring divider, ram read and write-back before the next acceptance;
// reads pass ram read and write-back, uncounted adds prep and a zero response, and
// command 3 only the zero response. rsp_valid rises at the edge that ends write-back
// or the zero response.
// Reset: a clearing pass writes zero to every bin, with req_ready low. A stalled
// rsp holds its result; the next command is still accepted and waits at write-back
// or the zero response until the output register is free.
// depends on hbc_pkg, hbc_ram, hbc_div
module histogram_bin_counter #(
   parameter int MAX_BINS = hbc_pkg::DefaultMaxBins
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  hbc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output hbc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hbc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [hbc_pkg::CsrDataWidth-1:0]  csr_data
);

   localparam int AddrWidth = $clog2(MAX_BINS);
   localparam int BinsCap   = (MAX_BINS < 511) ? MAX_BINS : 511;
   localparam int Sw        = hbc_pkg::SampleWidth;
   localparam int Cw        = hbc_pkg::CountWidth;
   localparam int Bw        = hbc_pkg::BinsWidth;
   localparam int Dw        = hbc_pkg::DiffWidth;
   localparam int Pw        = hbc_pkg::ProdWidth;
   localparam int Iw        = hbc_pkg::IndexWidth;

   localparam logic [3:0] StClear   = 4'd0;
   localparam logic [3:0] StIdle    = 4'd1;
   localparam logic [3:0] StPrep    = 4'd2;
   localparam logic [3:0] StMul     = 4'd3;
   localparam logic [3:0] StDivGo   = 4'd4;
   localparam logic [3:0] StDivWait = 4'd5;
   localparam logic [3:0] StRead    = 4'd6;
   localparam logic [3:0] StWrite   = 4'd7;
   localparam logic [3:0] StZero    = 4'd8;

   logic [3:0]             state_ff, state_in;
   hbc_pkg::req_type       req_ff, req_in;
   logic [Sw-1:0]          low_ff, low_in;
   logic [Sw-1:0]          high_ff, high_in;
   logic [Bw-1:0]          bins_ff, bins_in;
   logic [Dw-1:0]          diff_ff, diff_in;
   logic [Dw-1:0]          range_ff, range_in;
   logic [Bw-1:0]          binsel_ff, binsel_in;
   logic [Pw-1:0]          prod_ff, prod_in;
   logic [AddrWidth-1:0]   addr_ff, addr_in;
   logic [Iw-1:0]          idx_ff, idx_in;
   logic [AddrWidth-1:0]   clr_ff, clr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hbc_pkg::rsp_type       rsp_ff, rsp_in;

   logic signed [Dw-1:0]   diff_s;
   logic signed [Dw-1:0]   range_s;
   logic [Bw-1:0]          bins_eff;
   logic                   in_range;
   logic                   slot_free;
   logic [Cw-1:0]          bumped;

   logic                   ram_wr_en;
   logic [AddrWidth-1:0]   ram_wr_addr;
   logic [Cw-1:0]          ram_wr_data;
   logic                   ram_rd_en;
   logic [Cw-1:0]          ram_rd_data;

   logic                   div_start;
   logic                   div_done;
   logic [hbc_pkg::QuotWidth-1:0] div_quot;

   hbc_ram #(
      .WIDTH (Cw),
      .DEPTH (MAX_BINS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   hbc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (prod_ff),
      .denom (range_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      diff_s  = $signed({req_ff.sample[Sw-1], req_ff.sample})
              - $signed({low_ff[Sw-1], low_ff});
      range_s = $signed({high_ff[Sw-1], high_ff}) - $signed({low_ff[Sw-1], low_ff});
      if (int'(bins_ff) > BinsCap) begin
         bins_eff = Bw'(BinsCap);
      end else begin
         bins_eff = bins_ff;
      end
      in_range  = (int'(req_data.read_bin) < MAX_BINS);
      slot_free = !rsp_valid_ff || rsp_ready;
      bumped    = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + Cw'(1);

      state_in     = state_ff;
      req_in       = req_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      bins_in      = bins_ff;
      diff_in      = diff_ff;
      range_in     = range_ff;
      binsel_in    = binsel_ff;
      prod_in      = prod_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      div_start   = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            hbc_pkg::CsrLowLimit:  low_in  = csr_data;
            hbc_pkg::CsrHighLimit: high_in = csr_data;
            hbc_pkg::CsrBinsInUse: bins_in = csr_data[Bw-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         StClear: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + AddrWidth'(1);
            if (clr_ff == AddrWidth'(MAX_BINS - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (req_valid) begin
               req_in  = req_data;
               addr_in = AddrWidth'(req_data.read_bin);
               idx_in  = '0;
               case (req_data.command)
                  hbc_pkg::CmdAdd: state_in = StPrep;
                  hbc_pkg::CmdRead, hbc_pkg::CmdReadClear: begin
                     idx_in   = req_data.read_bin;
                     state_in = in_range ? StRead : StZero;
                  end
                  default: state_in = StZero;
               endcase
            end
         end
         StPrep: begin
            diff_in   = diff_s;
            range_in  = range_s;
            binsel_in = bins_eff;
            if ((range_s > 0) && (diff_s >= 0) && (bins_eff != '0) && (diff_s < range_s)) begin
               state_in = StMul;
            end else begin
               state_in = StZero;
            end
         end
         StMul: begin
            prod_in  = Pw'(diff_ff) * Pw'(binsel_ff);
            state_in = StDivGo;
         end
         StDivGo: begin
            div_start = 1'b1;
            state_in  = StDivWait;
         end
         StDivWait: begin
            if (div_done) begin
               addr_in  = AddrWidth'(div_quot);
               idx_in   = Iw'(div_quot);
               state_in = StRead;
            end
         end
         StRead: begin
            ram_rd_en = 1'b1;
            state_in  = StWrite;
         end
         StWrite: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.bin_index      = idx_ff;
               if (req_ff.command == hbc_pkg::CmdAdd) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_data        = bumped;
                  rsp_in.counted     = 1'b1;
                  rsp_in.count_value = bumped;
               end else begin
                  ram_wr_en          = (req_ff.command == hbc_pkg::CmdReadClear);
                  rsp_in.counted     = 1'b0;
                  rsp_in.count_value = ram_rd_data;
               end
               state_in = StIdle;
            end
         end
         StZero: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.bin_index   = idx_ff;
               rsp_in.counted     = 1'b0;
               rsp_in.count_value = '0;
               state_in           = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         low_ff       <= hbc_pkg::LowLimitReset;
         high_ff      <= hbc_pkg::HighLimitReset;
         bins_ff      <= hbc_pkg::BinsInUseReset;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         bins_ff      <= bins_in;
      end
      req_ff    <= req_in;
      diff_ff   <= diff_in;
      range_ff  <= range_in;
      binsel_ff <= binsel_in;
      prod_ff   <= prod_in;
      addr_ff   <= addr_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== rtl/core/hbc_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module hbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hbc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on hbc_pkg; numerator must satisfy numer < denom * 2**QuotWidth
module hbc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hbc_pkg::ProdWidth-1:0] numer,
   input  logic [hbc_pkg::DiffWidth-1:0] denom,
   output logic                           done,
   output logic [hbc_pkg::QuotWidth-1:0] quot
);

   localparam int Qw        = hbc_pkg::QuotWidth;
   localparam int Dw        = hbc_pkg::DiffWidth;
   localparam int StepWidth = $clog2(Qw + 1);

   logic [Dw-1:0]        rem_ff, rem_in;
   logic [Dw-1:0]        den_ff, den_in;
   logic [Qw-1:0]        low_ff, low_in;
   logic [Qw-1:0]        quot_ff, quot_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [Dw:0] trial;
   logic [Dw:0] trial_sub;
   logic        fits;

   always_comb begin
      trial     = {rem_ff, low_ff[Qw-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = numer[hbc_pkg::ProdWidth-1:Qw];
         low_in  = numer[Qw-1:0];
         den_in  = denom;
         step_in = StepWidth'(Qw);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[Dw-1:0] : trial[Dw-1:0];
         low_in  = {low_ff[Qw-2:0], 1'b0};
         quot_in = {quot_ff[Qw-2:0], fits};
         step_in = step_ff - StepWidth'(1);
         if (step_ff == StepWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/core/hbc_checker.sv =====
// port-level checks for the histogram bin counter, bound to the top level
// depends on hbc_pkg and assert_macros.svh
`include "assert_macros.svh"

module hbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hbc_pkg::rsp_type rsp_data
);

   // stalled result holds
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled rsp transaction changed")

   // a counted sample leaves a nonzero count
   `ASSERT_SAME_CYCLE(a_counted_nonzero, clock, reset, rsp_valid && rsp_data.counted, rsp_data.count_value != '0, "counted result with zero count")

   // store clearing keeps req closed right after reset
   `ASSERT_SAME_CYCLE(a_clear_after_reset, clock, reset, $past(reset), !req_ready, "req_ready high during clearing pass")

   // one command in flight at a time
   `ASSERT_NEXT_CYCLE(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "req_ready high right after a req transaction")

endmodule

bind histogram_bin_counter hbc_checker u_hbc_checker (.*);

// ===== verif/tb.sv =====
// self-checking testbench for histogram_bin_counter: random and directed commands
// on the req channel, results checked against an in-bench model of the bin counts
// depends on hbc_pkg and histogram_bin_counter
module tb;

   localparam logic [hbc_pkg::CmdWidth-1:0] CmdUnused = 2'd3;
   localparam int MaxBins = hbc_pkg::DefaultMaxBins;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   hbc_pkg::req_type                  req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   hbc_pkg::rsp_type                  rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [hbc_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [hbc_pkg::CsrDataWidth-1:0]  csr_data = '0;

   histogram_bin_counter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // shadow of the block's state
   logic [hbc_pkg::CountWidth-1:0]         bin_tally [MaxBins];
   logic signed [hbc_pkg::SampleWidth-1:0] low_lim = hbc_pkg::LowLimitReset;
   logic signed [hbc_pkg::SampleWidth-1:0] high_lim = hbc_pkg::HighLimitReset;
   logic [hbc_pkg::BinsWidth-1:0]          bins_cfg = hbc_pkg::BinsInUseReset;

   hbc_pkg::req_type command_fifo [$];
   hbc_pkg::rsp_type bin_reports [$];
   int      error_count = 0;
   int      csr_writes = 0;
   int      gap_pct = 0;
   int      stall_pct = 0;
   logic    req_taken = 1'b0;

   task automatic report_error(input string msg);
      if (error_count < 50) $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic hbc_pkg::rsp_type histogram_apply(input hbc_pkg::req_type item);
      hbc_pkg::rsp_type res;
      longint  v, lo, hi, nb, b;
      res = '0;
      case (item.command)
         hbc_pkg::CmdAdd: begin
            v = longint'($signed(item.sample));
            lo = longint'(low_lim);
            hi = longint'(high_lim);
            nb = (bins_cfg > MaxBins) ? MaxBins : bins_cfg;
            if (hi > lo && v >= lo && nb > 0) begin
               b = ((v - lo) * nb) / (hi - lo);
               if (b < nb) begin
                  if (~&bin_tally[b]) bin_tally[b] = bin_tally[b] + 1'b1;
                  res.bin_index = b[hbc_pkg::IndexWidth-1:0];
                  res.counted = 1'b1;
                  res.count_value = bin_tally[b];
               end
            end
         end
         hbc_pkg::CmdRead, hbc_pkg::CmdReadClear: begin
            res.bin_index = item.read_bin;
            res.count_value = bin_tally[item.read_bin];
            if (item.command == hbc_pkg::CmdReadClear) bin_tally[item.read_bin] = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (!req_valid || req_taken) begin
         if (command_fifo.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_data <= command_fifo.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      hbc_pkg::rsp_type want;
      req_taken <= req_valid && req_ready;
      if (reset) begin
         foreach (bin_tally[i]) bin_tally[i] = '0;
         low_lim = hbc_pkg::LowLimitReset;
         high_lim = hbc_pkg::HighLimitReset;
         bins_cfg = hbc_pkg::BinsInUseReset;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hbc_pkg::CsrLowLimit:  low_lim = csr_data;
               hbc_pkg::CsrHighLimit: high_lim = csr_data;
               hbc_pkg::CsrBinsInUse: bins_cfg = csr_data[hbc_pkg::BinsWidth-1:0];
               default: ;
            endcase
            csr_writes++;
         end
         if (req_valid && req_ready) bin_reports.push_back(histogram_apply(req_data));
         if (rsp_valid && rsp_ready) begin
            if (bin_reports.size() == 0) begin
               report_error($sformatf("transaction with nothing outstanding: bin %0d count %0d",
                  rsp_data.bin_index, rsp_data.count_value));
            end else begin
               want = bin_reports.pop_front();
               if (rsp_data.bin_index !== want.bin_index)
                  report_error($sformatf("bin_index got %0d want %0d",
                     rsp_data.bin_index, want.bin_index));
               if (rsp_data.counted !== want.counted)
                  report_error($sformatf("counted got %0b want %0b (bin %0d)",
                     rsp_data.counted, want.counted, want.bin_index));
               if (rsp_data.count_value !== want.count_value)
                  report_error($sformatf("count_value got %0d want %0d (bin %0d)",
                     rsp_data.count_value, want.count_value, want.bin_index));
            end
         end
      end
   end

   task automatic queue_cmd(input logic [hbc_pkg::CmdWidth-1:0] cmd,
                            input logic [hbc_pkg::SampleWidth-1:0] s,
                            input logic [hbc_pkg::IndexWidth-1:0] rb);
      hbc_pkg::req_type item;
      item.command = cmd;
      item.sample = s;
      item.read_bin = rb;
      command_fifo.push_back(item);
   endtask

   // checked at the rising edge, away from the driver's pops
   task automatic settle();
      do @(posedge clock);
      while (command_fifo.size() != 0 || req_valid || bin_reports.size() != 0);
   endtask

   task automatic write_csr(input logic [hbc_pkg::CsrIndexWidth-1:0] idx,
                            input logic [hbc_pkg::CsrDataWidth-1:0] val);
      int target;
      target = csr_writes + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock);
      while (csr_writes != target);
      csr_valid <= 1'b0;
   endtask

   task automatic set_range(input int lo, input int hi, input int nb);
      settle();
      write_csr(hbc_pkg::CsrLowLimit, 16'(lo));
      write_csr(hbc_pkg::CsrHighLimit, 16'(hi));
      write_csr(hbc_pkg::CsrBinsInUse, {7'($urandom), 9'(nb)});
      @(posedge clock);
   endtask

   function automatic logic [hbc_pkg::SampleWidth-1:0] random_sample();
      int lo, hi, r;
      lo = low_lim;
      hi = high_lim;
      r = $urandom_range(99);
      if (r < 70 && hi > lo) return 16'(lo + int'($urandom_range(hi - lo)));
      if (r < 85) begin
         case ($urandom_range(3))
            0: return 16'(lo);
            1: return 16'(lo - 1);
            2: return 16'(hi);
            default: return 16'(hi - 1);
         endcase
      end
      return 16'($urandom);
   endfunction

   task automatic random_item();
      int r, eff;
      logic [hbc_pkg::CmdWidth-1:0]   cmd;
      logic [hbc_pkg::IndexWidth-1:0] rb;
      r = $urandom_range(99);
      eff = (bins_cfg > MaxBins) ? MaxBins : bins_cfg;
      if (eff == 0) eff = 1;
      if (r < 65) cmd = hbc_pkg::CmdAdd;
      else if (r < 85) cmd = hbc_pkg::CmdRead;
      else if (r < 95) cmd = hbc_pkg::CmdReadClear;
      else cmd = CmdUnused;
      rb = ($urandom_range(99) < 70) ? 8'($urandom_range(eff - 1)) : 8'($urandom);
      queue_cmd(cmd, random_sample(), rb);
   endtask

   initial begin
      int lo;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: low 0, high 32767, 256 bins
      queue_cmd(hbc_pkg::CmdRead, 16'($urandom), 8'd0);
      queue_cmd(hbc_pkg::CmdRead, 16'($urandom), 8'd255);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd0, 8'($urandom));
      queue_cmd(hbc_pkg::CmdAdd, 16'sd32766, 8'($urandom));
      queue_cmd(hbc_pkg::CmdAdd, 16'sd32767, 8'($urandom));
      queue_cmd(hbc_pkg::CmdAdd, -16'sd32768, 8'($urandom));
      queue_cmd(hbc_pkg::CmdAdd, -16'sd1, 8'($urandom));
      queue_cmd(hbc_pkg::CmdAdd, 16'sd128, 8'($urandom));
      queue_cmd(hbc_pkg::CmdAdd, 16'sd0, 8'($urandom));
      queue_cmd(hbc_pkg::CmdReadClear, 16'($urandom), 8'd0);
      queue_cmd(hbc_pkg::CmdRead, 16'($urandom), 8'd0);
      queue_cmd(CmdUnused, 16'($urandom), 8'($urandom));
      // single bin over the full range
      set_range(-32768, 32767, 1);
      queue_cmd(hbc_pkg::CmdAdd, -16'sd32768, 8'd255);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd32767, 8'd0);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd32766, 8'd0);
      // bin count above the store size
      set_range(-32768, 32767, 511);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd32766, 8'd0);
      queue_cmd(hbc_pkg::CmdAdd, -16'sd32768, 8'd0);
      // empty and reversed ranges, zero bins
      set_range(100, 100, 8);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd100, 8'd0);
      set_range(200, 100, 8);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd150, 8'd0);
      set_range(0, 10, 0);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd5, 8'd0);
      // range of one step at the top
      set_range(32766, 32767, 256);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd32766, 8'd0);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd32767, 8'd0);
      // bins that do not divide the range
      set_range(-10, 10, 3);
      queue_cmd(hbc_pkg::CmdAdd, -16'sd10, 8'd0);
      queue_cmd(hbc_pkg::CmdAdd, 16'sd9, 8'd0);
      queue_cmd(hbc_pkg::CmdReadClear, 16'($urandom), 8'd2);

      for (int k = 0; k < 8; k++) begin
         if (k % 2 == 0) begin
            settle();
            case (k / 2)
               0: begin gap_pct = 0;  stall_pct = 0;  end
               1: begin gap_pct = 78; stall_pct = 0;  end
               2: begin gap_pct = 0;  stall_pct = 78; end
               default: begin gap_pct = 37; stall_pct = 37; end
            endcase
         end
         // each half starts from an empty pipeline
         case (k)
            0: set_range(-1000, 1000, 16);
            1: set_range(-32768, 32767, 256);
            2: set_range(0, 10, 3);
            4: set_range(32766, 32767, 256);
            5: set_range(500, -500, 8);
            6: set_range(-32768, -32000, 511);
            default: begin
               lo = int'($urandom_range(64768)) - 32768;
               set_range(lo, lo + 1 + int'($urandom_range(32766 - lo)),
                         int'($urandom_range(1, 300)));
            end
         endcase
         repeat (137) random_item();
      end

      settle();
      repeat (40) @(posedge clock);
      if (error_count == 0 && bin_reports.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
